// File: rtl/core/lfb_pkg.sv
package lfb_pkg;

    localparam int PANEL_WIDTH  = 84;
    localparam int PANEL_HEIGHT = 48;
    localparam int BUFFER_BYTES = 504;

    localparam int ADDR_W      = $clog2(BUFFER_BYTES);
    localparam int IDX_W       = 11;
    localparam int REFRESH_LEN = 2 + BUFFER_BYTES;
    localparam int INIT_LEN    = 8 + BUFFER_BYTES + 2;
    localparam int POS_W       = $clog2(INIT_LEN + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] CMD_SET_PIXEL = 3'd0;
    localparam logic [2:0] CMD_CLEAR     = 3'd1;
    localparam logic [2:0] CMD_REFRESH   = 3'd2;
    localparam logic [2:0] CMD_INIT      = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;

    localparam logic [7:0] CONTRAST_RESET = 8'hB0;
    localparam logic [7:0] BYTE_SET_X     = 8'h80;
    localparam logic [7:0] BYTE_SET_Y     = 8'h40;
    localparam logic [7:0] BYTE_BLANK     = 8'h08;
    localparam logic [7:0] BYTE_NORMAL    = 8'h0C;

    typedef enum logic [2:0] {
        OP_SET_PIXEL,
        OP_CLEAR,
        OP_REFRESH,
        OP_INIT,
        OP_TICK,
        OP_BAD
    } op_t;

    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_REFRESH,
        KIND_INIT
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_FETCH,
        ST_EXEC
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic              pix_ok;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
        logic              pixel_on;
    } work_t;

    function automatic logic [7:0] init_head(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h21;
            3'd1:    b = 8'h13;
            3'd2:    b = 8'h06;
            3'd3:    b = 8'hC2;
            3'd4:    b = 8'h20;
            3'd5:    b = 8'h09;
            3'd6:    b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/lcd_framebuffer_serial_refresh.sv
// Frame buffer for an 84x48 monochrome panel with a serial refresh engine. The
// front end takes one transfer a cycle into a four-entry queue while the queue
// has room; the back end serves one item at a time in two steps (a buffer memory
// read, then the result register) and fetches the next only once the result is
// loaded. After reset the buffer is zeroed by a clearing pass over all 504 bytes
// with s_tready low, and a clear command holds further items in the queue while
// the memory is swept again, one byte per cycle.
module lcd_framebuffer_serial_refresh (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,  // contrast_command
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // pixel_x, pixel_y, pixel_on, zero pad
    input  logic [2:0]  s_tuser,      // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata       // chip_select_n, data_mode, serial_data,
                                      // serial_clock, busy_res, rejected, zero pad
);
    import lfb_pkg::*;

    logic  q_push, q_pop, q_full, q_empty, init_done;
    work_t q_push_data, q_pop_data;

    lfb_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_full      (q_full),
        .init_done   (init_done),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    lfb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    lfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_data      (q_pop_data),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .init_done   (init_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> m_tdata[4])
        else $error("chip select low without a sequence in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5]) |-> (m_tdata[0] && !m_tdata[1] && !m_tdata[3]))
        else $error("rejected transfer drove the serial pins");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(init_done) |-> q_empty)
        else $error("item queued during the clearing pass");
`endif

endmodule

// File: rtl/core/lfb_front.sv
module lfb_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // pixel_x, pixel_y, pixel_on, zero pad
    input  logic [2:0]           s_tuser,    // command
    input  logic                 q_full,
    input  logic                 init_done,
    output logic                 q_push,
    output lfb_pkg::work_t       q_push_data
);
    import lfb_pkg::*;

    logic [6:0]       pixel_x;
    logic [5:0]       pixel_y;
    logic [IDX_W-1:0] pix_idx;
    op_t              op;

    assign pixel_x = s_tdata[6:0];
    assign pixel_y = s_tdata[12:7];

    always_comb
    begin
        unique case (s_tuser)
            CMD_SET_PIXEL: op = OP_SET_PIXEL;
            CMD_CLEAR:     op = OP_CLEAR;
            CMD_REFRESH:   op = OP_REFRESH;
            CMD_INIT:      op = OP_INIT;
            CMD_TICK:      op = OP_TICK;
            default:       op = OP_BAD;
        endcase
    end

    assign pix_idx = IDX_W'(pixel_y[5:3]) * IDX_W'(PANEL_WIDTH) + IDX_W'(pixel_x);

    always_comb
    begin
        q_push_data.op       = op;
        q_push_data.pix_ok   = ({1'b0, pixel_x} < 8'(PANEL_WIDTH))
                            && ({1'b0, pixel_y} < 7'(PANEL_HEIGHT))
                            && (pix_idx < IDX_W'(BUFFER_BYTES));
        q_push_data.addr     = pix_idx[ADDR_W-1:0];
        q_push_data.bit_sel  = pixel_y[2:0];
        q_push_data.pixel_on = s_tdata[13];
    end

    assign s_tready = !q_full && init_done;
    assign q_push   = s_tvalid && s_tready;

endmodule

// File: rtl/core/lfb_queue.sv
module lfb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lfb_pkg::work_t push_data,
    input  logic           pop,
    output lfb_pkg::work_t pop_data,
    output logic           full,
    output logic           empty
);
    import lfb_pkg::*;

    work_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/lfb_back.sv
module lfb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [7:0]     cfg_wr_data,
    input  lfb_pkg::work_t q_data,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           init_done,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata
);
    import lfb_pkg::*;

    logic [7:0]        fb_mem [BUFFER_BYTES];
    logic [7:0]        rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    back_state_t       state_reg, state_next;
    work_t             cur_reg, cur_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              init_done_reg, init_done_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [2:0]        bit_reg, bit_next;
    logic              phase_reg, phase_next;
    kind_t             kind_reg, kind_next;
    logic [7:0]        contrast_reg;
    logic              out_valid_reg, out_valid_next;
    logic [5:0]        out_reg, out_next;

    logic              out_load;
    logic              active;
    logic [7:0]        tx_byte;
    logic              tx_is_data;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  seq_len;
    logic [POS_W-1:0]  data_pos;
    logic              cs_n, dmode, sdata, sclk, busy, rej;

    assign out_load  = !out_valid_reg || m_tready;
    assign active    = (kind_reg != KIND_IDLE);
    assign pos_inc   = pos_reg + 1'b1;
    assign data_pos  = pos_reg - POS_W'(2);
    assign init_done = init_done_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_reg};

    always_comb
    begin
        tx_byte    = 8'h00;
        tx_is_data = 1'b0;
        seq_len    = '0;
        unique case (kind_reg)
            KIND_REFRESH:
            begin
                seq_len = POS_W'(REFRESH_LEN);
                if (pos_reg == POS_W'(0))
                begin
                    tx_byte = BYTE_SET_X;
                end
                else if (pos_reg == POS_W'(1))
                begin
                    tx_byte = BYTE_SET_Y;
                end
                else
                begin
                    tx_byte    = rd_data_reg;
                    tx_is_data = 1'b1;
                end
            end
            KIND_INIT:
            begin
                seq_len = POS_W'(INIT_LEN);
                if (pos_reg < POS_W'(7))
                begin
                    tx_byte = init_head(pos_reg[2:0]);
                end
                else if (pos_reg == POS_W'(7))
                begin
                    tx_byte = contrast_reg;
                end
                else if (pos_reg < POS_W'(8 + BUFFER_BYTES))
                begin
                    tx_is_data = 1'b1;
                end
                else if (pos_reg == POS_W'(8 + BUFFER_BYTES))
                begin
                    tx_byte = BYTE_BLANK;
                end
                else
                begin
                    tx_byte = BYTE_NORMAL;
                end
            end
            default:
            begin
                tx_byte = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        clr_addr_next  = clr_addr_reg;
        init_done_next = init_done_reg;
        pos_next       = pos_reg;
        bit_next       = bit_reg;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = clr_addr_reg;
        mem_wdata      = 8'h00;
        mem_re         = 1'b0;
        mem_raddr      = data_pos[ADDR_W-1:0];
        cs_n           = 1'b1;
        dmode          = 1'b0;
        sdata          = 1'b0;
        sclk           = 1'b0;
        busy           = 1'b0;
        rej            = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(BUFFER_BYTES - 1))
                begin
                    clr_addr_next  = '0;
                    init_done_next = 1'b1;
                    state_next     = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_data;
                    mem_re     = 1'b1;
                    if (q_data.op == OP_SET_PIXEL)
                    begin
                        mem_raddr = q_data.addr;
                    end
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_load)
                begin
                    state_next = ST_FETCH;
                    if (cur_reg.op == OP_TICK)
                    begin
                        if (active)
                        begin
                            cs_n  = 1'b0;
                            dmode = tx_is_data;
                            sdata = tx_byte[~bit_reg];
                            sclk  = phase_reg;
                            busy  = 1'b1;
                            phase_next = !phase_reg;
                            if (phase_reg)
                            begin
                                bit_next = bit_reg + 1'b1;
                                if (bit_reg == 3'd7)
                                begin
                                    pos_next = pos_inc;
                                    if (pos_inc >= seq_len)
                                    begin
                                        kind_next = KIND_IDLE;
                                        pos_next  = '0;
                                    end
                                end
                            end
                        end
                    end
                    else if (active || cur_reg.op == OP_BAD)
                    begin
                        rej  = 1'b1;
                        busy = active;
                    end
                    else
                    begin
                        unique case (cur_reg.op)
                            OP_SET_PIXEL:
                            begin
                                if (!cur_reg.pix_ok)
                                begin
                                    rej = 1'b1;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = cur_reg.addr;
                                    mem_wdata = rd_data_reg;
                                    mem_wdata[cur_reg.bit_sel] = cur_reg.pixel_on;
                                end
                            end
                            OP_CLEAR:
                            begin
                                clr_addr_next = '0;
                                state_next    = ST_CLEAR;
                            end
                            OP_REFRESH:
                            begin
                                kind_next  = KIND_REFRESH;
                                pos_next   = '0;
                                bit_next   = '0;
                                phase_next = 1'b0;
                                busy       = 1'b1;
                            end
                            OP_INIT:
                            begin
                                kind_next  = KIND_INIT;
                                pos_next   = '0;
                                bit_next   = '0;
                                phase_next = 1'b0;
                                busy       = 1'b1;
                            end
                            default:
                            begin
                                rej = 1'b1;
                            end
                        endcase
                    end
                    out_valid_next = 1'b1;
                    out_next       = {rej, busy, sclk, sdata, dmode, cs_n};
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            init_done_reg <= 1'b0;
            pos_reg       <= '0;
            bit_reg       <= '0;
            phase_reg     <= 1'b0;
            kind_reg      <= KIND_IDLE;
            contrast_reg  <= CONTRAST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            init_done_reg <= init_done_next;
            pos_reg       <= pos_next;
            bit_reg       <= bit_next;
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                contrast_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fb_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= fb_mem[mem_raddr];
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

    import lfb_pkg::*;

    localparam int         CYCLE_LIMIT   = 20_000_000;
    localparam int         REPORT_CAP    = 200;
    localparam logic [2:0] CMD_FIRST_BAD = 3'd5;
    localparam logic [2:0] CMD_LAST_BAD  = 3'd7;
    localparam logic [7:0] INIT_HEAD [7] = '{8'h21, 8'h13, 8'h06, 8'hC2, 8'h20, 8'h09, 8'h80};

    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] px;
        logic [5:0] py;
        logic       pix_on;
    } lcd_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic [2:0]  s_tuser = 3'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    lcd_item_t   pending[$];
    logic [7:0]  pin_states[$];

    logic [7:0]  fb_mem [BUFFER_BYTES];
    int          seq_pos;
    logic [2:0]  bit_pos;
    logic        clk_ph;
    kind_t       seq_kind;
    logic [7:0]  contrast_q;

    int          cycle_cnt = 0;
    int          err_cnt = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_halves = 0;
    int          src_wait = 0;
    int          sink_wait = 0;
    int          hold_left = 0;
    int          hold_timer = 3000;
    string       fld_name [8] = '{"chip_select_n", "data_mode", "serial_data",
                                  "serial_clock", "busy_res", "rejected", "pad6", "pad7"};

    lcd_framebuffer_serial_refresh i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_cnt % 4096) < 1024 || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Advances the panel state by one command and returns the pins it produces.
    function automatic logic [7:0] lcd_predict(input logic [2:0] cmd, input logic [6:0] px,
                                               input logic [5:0] py, input logic pix_on);
        logic [7:0] pins;
        logic [7:0] sbyte;
        logic       is_data;
        int         idx;
        int         seq_len;
        pins = 8'b0000_0001;
        if (cmd == CMD_TICK)
        begin
            if (seq_kind != KIND_IDLE)
            begin
                is_data = 1'b0;
                if (seq_kind == KIND_REFRESH)
                begin
                    seq_len = REFRESH_LEN;
                    if (seq_pos == 0)
                        sbyte = BYTE_SET_X;
                    else if (seq_pos == 1)
                        sbyte = BYTE_SET_Y;
                    else
                    begin
                        sbyte = fb_mem[seq_pos - 2];
                        is_data = 1'b1;
                    end
                end
                else
                begin
                    seq_len = INIT_LEN;
                    if (seq_pos < 7)
                        sbyte = INIT_HEAD[seq_pos];
                    else if (seq_pos == 7)
                        sbyte = contrast_q;
                    else if (seq_pos < 8 + BUFFER_BYTES)
                    begin
                        sbyte = 8'd0;
                        is_data = 1'b1;
                    end
                    else if (seq_pos == 8 + BUFFER_BYTES)
                        sbyte = BYTE_BLANK;
                    else
                        sbyte = BYTE_NORMAL;
                end
                pins[0] = 1'b0;
                pins[1] = is_data;
                pins[2] = sbyte[3'd7 - bit_pos];
                pins[3] = clk_ph;
                pins[4] = 1'b1;
                if (!clk_ph)
                    clk_ph = 1'b1;
                else
                begin
                    clk_ph = 1'b0;
                    bit_pos = bit_pos + 3'd1;
                    if (bit_pos == 3'd0)
                    begin
                        seq_pos = seq_pos + 1;
                        if (seq_pos >= seq_len)
                        begin
                            seq_kind = KIND_IDLE;
                            seq_pos = 0;
                        end
                    end
                end
            end
        end
        else
        begin
            if (seq_kind != KIND_IDLE || cmd > CMD_TICK)
                pins[5] = 1'b1;
            else
            begin
                case (cmd)
                    CMD_SET_PIXEL:
                    begin
                        idx = int'(py >> 3) * PANEL_WIDTH + int'(px);
                        if (px >= PANEL_WIDTH || py >= PANEL_HEIGHT || idx >= BUFFER_BYTES)
                            pins[5] = 1'b1;
                        else
                            fb_mem[idx][py[2:0]] = pix_on;
                    end
                    CMD_CLEAR:
                        for (int i = 0; i < BUFFER_BYTES; i++)
                            fb_mem[i] = 8'd0;
                    CMD_REFRESH:
                    begin
                        seq_kind = KIND_REFRESH;
                        seq_pos = 0;
                        bit_pos = 3'd0;
                        clk_ph = 1'b0;
                    end
                    CMD_INIT:
                    begin
                        seq_kind = KIND_INIT;
                        seq_pos = 0;
                        bit_pos = 3'd0;
                        clk_ph = 1'b0;
                    end
                    default:
                        pins[5] = 1'b1;
                endcase
            end
            pins[4] = (seq_kind != KIND_IDLE);
        end
        return pins;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        lcd_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 16'd0;
            s_tuser <= 3'd0;
            src_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pin_states.push_back(lcd_predict(s_tuser, s_tdata[6:0], s_tdata[12:7],
                                                 s_tdata[13]));
                n_items++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_wait != 0)
                begin
                    s_tvalid <= 1'b0;
                    src_wait <= src_wait - 1;
                end
                else if (pending.size() != 0)
                begin
                    nxt = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.cmd;
                    s_tdata <= {2'b00, nxt.pix_on, nxt.py, nxt.px};
                    src_wait <= pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Periodically the receiver stops for a long stretch so the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_timer <= 3000;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_timer == 0)
        begin
            hold_left <= 600;
            hold_timer <= 5000;
        end
        else
            hold_timer <= hold_timer - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : check_pins
        logic [7:0] want;
        int         w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (pin_states.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected transfer, got %08b", $time, m_tdata);
                end
                else
                begin
                    want = pin_states.pop_front();
                    for (int b = 0; b < 8; b++)
                    begin
                        if (m_tdata[b] !== want[b])
                        begin
                            err_cnt++;
                            if (err_cnt <= REPORT_CAP)
                                $display("%0t: %s expected %0b, got %0b (transfer %0d)",
                                         $time, fld_name[b], want[b], m_tdata[b], n_results);
                        end
                    end
                end
            end
            if (sink_wait != 0)
            begin
                m_tready <= 1'b0;
                sink_wait <= sink_wait - 1;
            end
            else if (hold_left != 0)
                m_tready <= 1'b0;
            else if (m_tvalid && m_tready)
            begin
                w = pick_gap();
                m_tready <= (w == 0);
                sink_wait <= (w == 0) ? 0 : w - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_item(input logic [2:0] cmd, input logic [6:0] px,
                              input logic [5:0] py, input logic pix_on);
        lcd_item_t t;
        t.cmd = cmd;
        t.px = px;
        t.py = py;
        t.pix_on = pix_on;
        pending.push_back(t);
    endtask

    task automatic queue_cmd(input logic [2:0] cmd);
        queue_item(cmd, 7'($urandom), 6'($urandom), 1'($urandom));
    endtask

    task automatic queue_pixel();
        logic [6:0] px;
        logic [5:0] py;
        px = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(PANEL_WIDTH, 127))
                                         : 7'($urandom_range(0, PANEL_WIDTH - 1));
        py = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(PANEL_HEIGHT, 63))
                                         : 6'($urandom_range(0, PANEL_HEIGHT - 1));
        queue_item(CMD_SET_PIXEL, px, py, $urandom_range(0, 9) < 7);
    endtask

    task automatic queue_mixed(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                queue_pixel();
            else if (r < 63)
                queue_cmd(CMD_CLEAR);
            else if (r < 88)
                queue_cmd(CMD_TICK);
            else
                queue_cmd(3'($urandom_range(CMD_FIRST_BAD, CMD_LAST_BAD)));
        end
    endtask

    // The start command, then a run of half-bit ticks, with an occasional
    // non-tick command in between that the block must refuse.
    task automatic queue_sequence(input kind_t kind, input int halves);
        int         pick;
        logic [2:0] cmd;
        if (kind == KIND_REFRESH)
            queue_cmd(CMD_REFRESH);
        else
            queue_cmd(CMD_INIT);
        for (int i = 0; i < halves; i++)
        begin
            if ($urandom_range(0, 99) < 2)
            begin
                pick = $urandom_range(0, 6);
                cmd = (pick < 4) ? 3'(pick) : 3'(pick + 1);
                queue_cmd(cmd);
            end
            queue_cmd(CMD_TICK);
            n_halves++;
        end
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || s_tvalid !== 1'b0 || pin_states.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_contrast(input logic [7:0] level);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= level;
        contrast_q = level;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < BUFFER_BYTES; i++)
            fb_mem[i] = 8'd0;
        seq_pos = 0;
        bit_pos = 3'd0;
        clk_ph = 1'b0;
        seq_kind = KIND_IDLE;
        contrast_q = CONTRAST_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        queue_item(CMD_TICK, 7'd0, 6'd0, 1'b0);
        queue_item(CMD_SET_PIXEL, 7'd0, 6'd0, 1'b1);
        queue_item(CMD_SET_PIXEL, 7'd83, 6'd47, 1'b1);
        queue_item(CMD_SET_PIXEL, 7'd83, 6'd0, 1'b1);
        queue_item(CMD_SET_PIXEL, 7'd0, 6'd47, 1'b1);
        queue_item(CMD_SET_PIXEL, 7'd84, 6'd0, 1'b1);
        queue_item(CMD_SET_PIXEL, 7'd0, 6'd48, 1'b1);
        queue_item(CMD_SET_PIXEL, 7'd127, 6'd63, 1'b1);
        queue_item(CMD_SET_PIXEL, 7'd127, 6'd0, 1'b0);
        queue_item(CMD_SET_PIXEL, 7'd42, 6'd21, 1'b1);
        queue_item(CMD_SET_PIXEL, 7'd42, 6'd21, 1'b0);
        queue_item(CMD_SET_PIXEL, 7'd42, 6'd22, 1'b1);
        for (int c = CMD_FIRST_BAD; c <= CMD_LAST_BAD; c++)
            queue_item(3'(c), 7'd127, 6'd63, 1'b1);
        queue_item(CMD_CLEAR, 7'd0, 6'd0, 1'b0);
        queue_item(CMD_SET_PIXEL, 7'd1, 6'd1, 1'b1);
        queue_item(CMD_SET_PIXEL, 7'd83, 6'd40, 1'b1);
        queue_item(CMD_TICK, 7'd127, 6'd63, 1'b1);

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph != 0)
            begin
                wait_idle();
                write_contrast((ph == 1) ? 8'd128 : 8'd255);
            end
            queue_mixed(440);
        end

        // Light up the start of the top band so the refresh carries real data.
        for (int i = 0; i < 40; i++)
            queue_item(CMD_SET_PIXEL, 7'($urandom_range(0, 27)), 6'($urandom_range(0, 7)),
                       1'b1);
        wait_idle();
        write_contrast(8'($urandom_range(129, 254)));
        queue_sequence(KIND_REFRESH, 480);

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Checked %0d transfers from %0d commands: pixel writes in and out of range,",
                 n_results, n_items);
        $display("clears, idle ticks and refused codes, then %0d half bits of a refresh.",
                 n_halves);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lfb_pkg.sv
rtl/core/lfb_front.sv
rtl/core/lfb_queue.sv
rtl/core/lfb_back.sv
rtl/core/lcd_framebuffer_serial_refresh.sv
test/tb.sv
